// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define BCK_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check that also holds while reset is held.
`define BCK_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/bck_pkg.sv
// Shared constants and types of the BMP colour-key replacement block.
`timescale 1ns / 1ps

package bck_pkg;

	// Image format limits
	localparam int HEADER_BYTES = 54;
	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_HEIGHT   = 4096;

	// Field and counter widths
	localparam int BYTE_W  = 8;
	localparam int DIM_W   = 13;
	localparam int COL_W   = 14;
	localparam int ROW_W   = 12;
	localparam int HDR_W   = $clog2(HEADER_BYTES + 1);
	localparam int CFG_IDX_W = 3;

	// Result queue geometry: up to three results per input byte
	localparam int PUSH_MAX    = 3;
	localparam int PUSH_W      = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_MATCH_RED    = 3'd2,
		REG_MATCH_GREEN  = 3'd3,
		REG_MATCH_BLUE   = 3'd4,
		REG_NEW_RED      = 3'd5,
		REG_NEW_GREEN    = 3'd6,
		REG_NEW_BLUE     = 3'd7
	} cfg_reg_t;

	// One result: output byte and its end-of-run mark
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} bck_entry_t;

	// Results produced by one input byte, entry 0 first
	typedef bck_entry_t [PUSH_MAX-1:0] bck_burst_t;

endpackage

// File: hw/rtl/bck_out_queue.sv
// Four-entry result queue taking up to three results per cycle.
`timescale 1ns / 1ps

module bck_out_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bck_pkg::PUSH_W-1:0] push_cnt,
	input  bck_pkg::bck_burst_t       push_ent,
	input  logic                      pop,
	output logic [bck_pkg::QCNT_W-1:0] count,
	output bck_pkg::bck_entry_t       head
);
	import bck_pkg::*;

	bck_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Entry storage: results land in consecutive slots from the write pointer
	always_ff @(posedge clk) begin
		for (int i = 0; i < PUSH_MAX; i++) begin
			if (PUSH_W'(i) < push_cnt) begin
				mem_q[wr_ptr_q + QPTR_W'(i)] <= push_ent[i];
			end
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	assign count = count_q;
	assign head  = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/bmp_color_key_replace.sv
// Top level: colour-key replacement on a 24-bit BMP byte stream.
//
//   channel   dir  handshake            payload
//   in        in   in_valid/in_ready    in_byte
//   out       out  out_valid/out_ready  out_byte, run_end
//   cfg       in   cfg_we (no wait)     cfg_index, cfg_data
//
// Sustains one input byte per cycle unless stalled; a result appears in the cycle
// after the byte that causes it, pixels as a burst of three into a four-entry
// queue. in_ready falls only when the queue lacks room for the results that the
// next byte will cause (known from the counters alone), i.e. on output stall.
// Reset clears the counters, the queue and the registers to their defaults.
`timescale 1ns / 1ps

module bmp_color_key_replace (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bck_pkg::BYTE_W-1:0]     in_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bck_pkg::BYTE_W-1:0]     out_byte,
	output logic                           run_end,
	input  logic                           cfg_we,
	input  logic [bck_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bck_pkg::DIM_W-1:0]      cfg_data
);
	import bck_pkg::*;

	// Configuration registers
	logic [DIM_W-1:0]  width_q, height_q;
	logic [BYTE_W-1:0] match_r_q, match_g_q, match_b_q;
	logic [BYTE_W-1:0] new_r_q, new_g_q, new_b_q;

	// Stream position
	logic [HDR_W-1:0]  header_q;
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        slot_q;
	logic [BYTE_W-1:0] held_q [2];

	// Derived geometry and decode
	logic [DIM_W-1:0]  w_dim, h_dim;
	logic [COL_W-1:0]  pix_bytes, row_len, col_nxt;
	logic [1:0]        pad_len;
	logic [ROW_W:0]    row_nxt;
	logic              hdr_phase, is_pad, is_hold, is_match, accept, pop;
	logic [PUSH_W-1:0] need;
	logic [QCNT_W-1:0] q_count;
	bck_burst_t        burst;
	bck_entry_t        q_head;

	// Dimensions: zero reads as one, oversize saturates
	always_comb begin
		if (width_q == '0)
			w_dim = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			w_dim = DIM_W'(MAX_WIDTH);
		else
			w_dim = width_q;
		if (height_q == '0)
			h_dim = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT))
			h_dim = DIM_W'(MAX_HEIGHT);
		else
			h_dim = height_q;
	end

	// Row geometry: three bytes per pixel, padded to a multiple of four
	assign pix_bytes = COL_W'(w_dim) + COL_W'({w_dim, 1'b0});
	assign pad_len   = 2'd0 - pix_bytes[1:0];
	assign row_len   = pix_bytes + COL_W'(pad_len);
	assign col_nxt   = column_q + COL_W'(1);
	assign row_nxt   = {1'b0, row_q} + (ROW_W+1)'(1);

	// Classify the next byte and how many results it will cause
	assign hdr_phase = header_q < HDR_W'(HEADER_BYTES);
	assign is_pad    = column_q >= pix_bytes;
	assign is_hold   = !hdr_phase && !is_pad && (slot_q < 2'd2);
	assign is_match  = (held_q[0] == match_b_q) && (held_q[1] == match_g_q)
		&& (in_byte == match_r_q);

	always_comb begin
		if (hdr_phase || is_pad)
			need = PUSH_W'(1);
		else if (is_hold)
			need = '0;
		else
			need = PUSH_W'(PUSH_MAX);
	end

	assign in_ready = (q_count + QCNT_W'(need)) <= QCNT_W'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	// Result burst for the queue
	always_comb begin
		burst = '0;
		if (hdr_phase) begin
			burst[0] = '{data: in_byte, last: 1'b1};
		end else if (is_pad) begin
			burst[0] = '{data: '0, last: 1'b1};
		end else if (is_match) begin
			burst[0] = '{data: new_b_q, last: 1'b0};
			burst[1] = '{data: new_g_q, last: 1'b0};
			burst[2] = '{data: new_r_q, last: 1'b1};
		end else begin
			burst[0] = '{data: held_q[0], last: 1'b0};
			burst[1] = '{data: held_q[1], last: 1'b0};
			burst[2] = '{data: in_byte, last: 1'b1};
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(1);
			height_q  <= DIM_W'(1);
			match_r_q <= '0;
			match_g_q <= '0;
			match_b_q <= '0;
			new_r_q   <= '0;
			new_g_q   <= '0;
			new_b_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q   <= cfg_data;
				REG_IMAGE_HEIGHT: height_q  <= cfg_data;
				REG_MATCH_RED:    match_r_q <= cfg_data[BYTE_W-1:0];
				REG_MATCH_GREEN:  match_g_q <= cfg_data[BYTE_W-1:0];
				REG_MATCH_BLUE:   match_b_q <= cfg_data[BYTE_W-1:0];
				REG_NEW_RED:      new_r_q   <= cfg_data[BYTE_W-1:0];
				REG_NEW_GREEN:    new_g_q   <= cfg_data[BYTE_W-1:0];
				REG_NEW_BLUE:     new_b_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stream position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			column_q <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (accept) begin
			if (hdr_phase) begin
				header_q <= header_q + HDR_W'(1);
			end else begin
				if (is_hold)
					slot_q <= slot_q + 2'd1;
				else if (!is_pad)
					slot_q <= '0;
				// row wrap, then image wrap back to the header
				if (col_nxt >= row_len) begin
					column_q <= '0;
					slot_q   <= '0;
					if (row_nxt >= (ROW_W+1)'(h_dim)) begin
						row_q    <= '0;
						header_q <= '0;
					end else begin
						row_q <= row_nxt[ROW_W-1:0];
					end
				end else begin
					column_q <= col_nxt;
				end
			end
		end
	end

	// Blue and green bytes of the pixel being gathered
	always_ff @(posedge clk) begin
		if (accept && is_hold)
			held_q[slot_q[0]] <= in_byte;
	end

	// Result queue
	assign pop = out_valid && out_ready;

	bck_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (accept ? need : PUSH_W'(0)),
		.push_ent (burst),
		.pop      (pop),
		.count    (q_count),
		.head     (q_head)
	);

	assign out_valid = q_count != '0;
	assign out_byte  = q_head.data;
	assign run_end   = q_head.last;

endmodule

// File: hw/rtl/bck_checker.sv
// Port-level checker for the colour-key replacement block, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bck_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_end
);

	// A waiting result stays offered
	`BCK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// A waiting result keeps its payload
	`BCK_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_byte, run_end}), "payload moved")

	// Nothing is offered while reset is held
	`BCK_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid, "result offered in reset")

	// With nothing queued there is always room for the next byte
	`BCK_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input stalled with empty queue")

	// Blue and green of a pixel are always followed by the rest of the pixel
	`BCK_ASSERT(a_pixel_burst, out_valid && out_ready && !run_end |=> out_valid, "pixel burst broken")

endmodule

bind bmp_color_key_replace bck_checker u_bck_checker (.*);
